/* sv/bums_pkg.sv */
// ============================================================================
// Bottom-up merge sorter package
// Shared widths, transfer payload types and controller states.
// ============================================================================
`default_nettype none

package bums_pkg;

    localparam int DATA_W       = 32;
    localparam int CAPACITY_DEF = 64;

    typedef struct packed {
        logic signed [DATA_W-1:0] value;
        logic                     is_last;
    } item_t;

    typedef struct packed {
        logic signed [DATA_W-1:0] sorted_value;
        logic                     final_res;
        logic                     overflowed;
    } result_t;

    typedef enum logic [2:0] {
        ST_LOAD,
        ST_PASS,
        ST_SETUP,
        ST_MERGE,
        ST_PRIME,
        ST_FIRST,
        ST_EMIT
    } state_t;

endpackage

`default_nettype wire

/* sv/bottom_up_merge_sorter_top.sv */
// ============================================================================
// Bottom-up merge sorter
// Collects a set of signed integers, sorts it ascending by bottom-up merge
// passes between two memories, and returns the sorted set.
// ============================================================================
// Loading accepts one item transfer per cycle; items are stalled while a set is
// sorted or returned. Sorting n items takes ceil(log2 n) passes that each write
// every item once, plus a setup step per pair of runs, one per pass and one to
// end the sort. Results follow ST_PRIME and ST_FIRST, one per cycle unless stalled.
// Reset clears the controller, the item count and the overflow flag; the
// memories hold undefined data until written.
`default_nettype none

module bottom_up_merge_sorter_top #(
    parameter int CAPACITY = bums_pkg::CAPACITY_DEF
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              item_valid,
    output logic                   item_stall,
    input  wire bums_pkg::item_t   item,
    output logic                   result_valid,
    input  wire logic              result_stall,
    output bums_pkg::result_t      result
);

    import bums_pkg::*;

    localparam int IDX_W = $clog2(CAPACITY);
    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int WID_W = CNT_W + 1;
    localparam int SUM_W = CNT_W + 2;
    localparam logic [CNT_W-1:0] CAP_C = CNT_W'(CAPACITY);

    state_t             state_reg, state_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic               ovf_reg, ovf_next;
    logic               src_reg, src_next;
    logic [WID_W-1:0]   width_reg, width_next;
    logic [CNT_W-1:0]   start_reg, start_next;
    logic [CNT_W-1:0]   md_reg, md_next;
    logic [CNT_W-1:0]   hi_reg, hi_next;
    logic [CNT_W-1:0]   p_reg, p_next;
    logic [CNT_W-1:0]   q_reg, q_next;
    logic [CNT_W-1:0]   k_reg, k_next;
    logic [CNT_W-1:0]   out_idx_reg, out_idx_next;
    logic               result_valid_reg, result_valid_next;
    result_t            result_reg, result_next;

    logic [DATA_W-1:0]  mem0 [CAPACITY];
    logic [DATA_W-1:0]  mem1 [CAPACITY];
    logic [DATA_W-1:0]  m0a_reg, m0b_reg, m1a_reg, m1b_reg;
    logic [IDX_W-1:0]   rd_a_addr, rd_b_addr, wr_addr;
    logic [DATA_W-1:0]  wr_data;
    logic               wr0_en, wr1_en;

    logic signed [DATA_W-1:0] a_data, b_data;
    logic [SUM_W-1:0]   n_ext, mid_sum, hi_sum;
    logic               take_left;

    assign a_data  = $signed(src_reg ? m1a_reg : m0a_reg);
    assign b_data  = $signed(src_reg ? m1b_reg : m0b_reg);
    assign n_ext   = SUM_W'(count_reg);
    assign mid_sum = SUM_W'(start_reg) + SUM_W'(width_reg);
    assign hi_sum  = mid_sum + SUM_W'(width_reg);
    assign take_left = (q_reg >= hi_reg) || ((p_reg < md_reg) && (a_data < b_data));

    always_ff @(posedge clk)
    begin
        if (wr0_en)
        begin
            mem0[wr_addr] <= wr_data;
        end
        if (wr1_en)
        begin
            mem1[wr_addr] <= wr_data;
        end
        m0a_reg <= mem0[rd_a_addr];
        m0b_reg <= mem0[rd_b_addr];
        m1a_reg <= mem1[rd_a_addr];
        m1b_reg <= mem1[rd_b_addr];
    end

    always_comb
    begin
        state_next        = state_reg;
        count_next        = count_reg;
        ovf_next          = ovf_reg;
        src_next          = src_reg;
        width_next        = width_reg;
        start_next        = start_reg;
        md_next           = md_reg;
        hi_next           = hi_reg;
        p_next            = p_reg;
        q_next            = q_reg;
        k_next            = k_reg;
        out_idx_next      = out_idx_reg;
        result_valid_next = result_valid_reg;
        result_next       = result_reg;
        item_stall        = 1'b1;
        wr0_en            = 1'b0;
        wr1_en            = 1'b0;
        wr_addr           = k_reg[IDX_W-1:0];
        wr_data           = take_left ? a_data : b_data;

        case (state_reg)
            ST_LOAD:
            begin
                item_stall = 1'b0;
                if (item_valid)
                begin
                    if (count_reg < CAP_C)
                    begin
                        wr0_en     = 1'b1;
                        wr_addr    = count_reg[IDX_W-1:0];
                        wr_data    = item.value;
                        count_next = count_reg + 1'b1;
                    end
                    else
                    begin
                        ovf_next = 1'b1;
                    end
                    if (item.is_last)
                    begin
                        width_next = WID_W'(1);
                        src_next   = 1'b0;
                        state_next = ST_PASS;
                    end
                end
            end
            ST_PASS:
            begin
                if (SUM_W'(width_reg) >= n_ext)
                begin
                    state_next = ST_PRIME;
                end
                else
                begin
                    start_next = '0;
                    state_next = ST_SETUP;
                end
            end
            ST_SETUP:
            begin
                md_next    = (mid_sum < n_ext) ? mid_sum[CNT_W-1:0] : count_reg;
                hi_next    = (hi_sum < n_ext) ? hi_sum[CNT_W-1:0] : count_reg;
                p_next     = start_reg;
                q_next     = md_next;
                k_next     = start_reg;
                state_next = ST_MERGE;
            end
            ST_MERGE:
            begin
                wr0_en = src_reg;
                wr1_en = !src_reg;
                if (take_left)
                begin
                    p_next = p_reg + 1'b1;
                end
                else
                begin
                    q_next = q_reg + 1'b1;
                end
                k_next = k_reg + 1'b1;
                if (CNT_W'(k_reg + 1'b1) == hi_reg)
                begin
                    if (hi_sum >= n_ext)
                    begin
                        width_next = width_reg << 1;
                        src_next   = !src_reg;
                        state_next = ST_PASS;
                    end
                    else
                    begin
                        start_next = hi_sum[CNT_W-1:0];
                        state_next = ST_SETUP;
                    end
                end
            end
            ST_PRIME:
            begin
                state_next = ST_FIRST;
            end
            ST_FIRST:
            begin
                out_idx_next             = '0;
                result_next.sorted_value = a_data;
                result_next.final_res    = (count_reg == CNT_W'(1));
                result_next.overflowed   = ovf_reg;
                result_valid_next        = 1'b1;
                state_next               = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (!result_stall)
                begin
                    if (CNT_W'(out_idx_reg + 1'b1) == count_reg)
                    begin
                        result_valid_next = 1'b0;
                        count_next        = '0;
                        ovf_next          = 1'b0;
                        state_next        = ST_LOAD;
                    end
                    else
                    begin
                        out_idx_next             = out_idx_reg + 1'b1;
                        result_next.sorted_value = a_data;
                        result_next.final_res    = (CNT_W'(out_idx_reg + 2'd2) == count_reg);
                        result_next.overflowed   = ovf_reg;
                    end
                end
            end
            default:
            begin
                state_next = ST_LOAD;
            end
        endcase
    end

    // Merge reads are issued for the next pointers so that a head arrives
    // every cycle; the result phase prefetches the element after the shown one.
    always_comb
    begin
        case (state_reg)
            ST_PRIME:
            begin
                rd_a_addr = '0;
                rd_b_addr = '0;
            end
            ST_FIRST, ST_EMIT:
            begin
                rd_a_addr = IDX_W'(out_idx_next + 1'b1);
                rd_b_addr = '0;
            end
            default:
            begin
                rd_a_addr = p_next[IDX_W-1:0];
                rd_b_addr = q_next[IDX_W-1:0];
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_LOAD;
            count_reg        <= '0;
            ovf_reg          <= 1'b0;
            src_reg          <= 1'b0;
            width_reg        <= '0;
            start_reg        <= '0;
            md_reg           <= '0;
            hi_reg           <= '0;
            p_reg            <= '0;
            q_reg            <= '0;
            k_reg            <= '0;
            out_idx_reg      <= '0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            count_reg        <= count_next;
            ovf_reg          <= ovf_next;
            src_reg          <= src_next;
            width_reg        <= width_next;
            start_reg        <= start_next;
            md_reg           <= md_next;
            hi_reg           <= hi_next;
            p_reg            <= p_next;
            q_reg            <= q_next;
            k_reg            <= k_next;
            out_idx_reg      <= out_idx_next;
            result_valid_reg <= result_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    // A result is only presented while the set is being returned.
    a_valid_in_emit: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid_reg |-> (state_reg == ST_EMIT))
        else $error("result valid outside the result phase");

    // Every element written so far came from exactly one of the two runs.
    a_merge_balance: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_MERGE) |->
            ((SUM_W'(p_reg) + SUM_W'(q_reg)) == (SUM_W'(k_reg) + SUM_W'(md_reg))))
        else $error("merge pointers out of balance");

    a_merge_bounds: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_MERGE) |-> ((k_reg < hi_reg) && (hi_reg <= count_reg)))
        else $error("merge write index beyond the run pair");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CAP_C)
        else $error("item count exceeds capacity");

    a_final_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && !result_stall && result.final_res) |=>
            ((state_reg == ST_LOAD) && (count_reg == '0) && !ovf_reg))
        else $error("set not cleared after its final transfer");

endmodule

`default_nettype wire

/* test/tb_top.sv */
`timescale 1ns / 100ps
// ============================================================================
// Testbench for the bottom-up merge sorter
// Sends sets of signed integers to the sorter. Each set is closed by an item
// that has the last flag set. The sets include single items, extreme values,
// duplicates, a set that fills the buffer exactly and sets that overflow it.
// A scoreboard sorts every accepted set itself. It then checks each returned
// transfer against the expected value, last marker and overflow flag. Both
// sides idle at random, and the receiver holds off once for a long stretch.
// ============================================================================

module tb_top;

    import bums_pkg::*;

    localparam int CYCLE_LIMIT = 200000;

    typedef enum int {
        VS_WIDE,
        VS_DUPS,
        VS_EDGES,
        VS_NARROW
    } value_style_t;

    class sort_scoreboard;
        logic signed [DATA_W-1:0] set_buf [CAPACITY_DEF];
        int                       set_count;
        bit                       set_overflow;
        result_t                  sorted_due [$];
        int                       mismatches;

        function new();
            set_count    = 0;
            set_overflow = 0;
            mismatches   = 0;
        endfunction

        function int pending();
            return sorted_due.size();
        endfunction

        function void accept_item(item_t it);
            logic signed [DATA_W-1:0] merged [CAPACITY_DEF];
            int      n;
            int      w;
            int      lo;
            int      mid;
            int      hi;
            int      p;
            int      q;
            int      k;
            result_t r;
            if (set_count < CAPACITY_DEF)
            begin
                set_buf[set_count] = it.value;
                set_count = set_count + 1;
            end
            else
            begin
                set_overflow = 1'b1;
            end
            if (!it.is_last)
                return;
            n = set_count;
            for (w = 1; w < n; w = w * 2)
            begin
                for (lo = 0; lo + w < n; lo = lo + 2 * w)
                begin
                    mid = lo + w;
                    hi  = (lo + 2 * w > n) ? n : lo + 2 * w;
                    p   = lo;
                    q   = mid;
                    k   = lo;
                    // On equal keys the right run goes first.
                    while (p < mid && q < hi)
                    begin
                        if (set_buf[p] < set_buf[q])
                        begin
                            merged[k] = set_buf[p];
                            p = p + 1;
                        end
                        else
                        begin
                            merged[k] = set_buf[q];
                            q = q + 1;
                        end
                        k = k + 1;
                    end
                    while (p < mid)
                    begin
                        merged[k] = set_buf[p];
                        p = p + 1;
                        k = k + 1;
                    end
                    while (q < hi)
                    begin
                        merged[k] = set_buf[q];
                        q = q + 1;
                        k = k + 1;
                    end
                    for (k = lo; k < hi; k++)
                        set_buf[k] = merged[k];
                end
            end
            for (k = 0; k < n; k++)
            begin
                r.sorted_value = set_buf[k];
                r.final_res    = (k == n - 1);
                r.overflowed   = set_overflow;
                sorted_due.push_back(r);
            end
            set_count    = 0;
            set_overflow = 1'b0;
        endfunction

        function void check_result(result_t got);
            result_t want;
            if (sorted_due.size() == 0)
            begin
                mismatches = mismatches + 1;
                if (mismatches <= 10)
                    $display("Unexpected result transfer: value %0d final %0b overflow %0b",
                             got.sorted_value, got.final_res, got.overflowed);
                return;
            end
            want = sorted_due.pop_front();
            if (got.sorted_value !== want.sorted_value || got.final_res !== want.final_res ||
                got.overflowed !== want.overflowed)
            begin
                mismatches = mismatches + 1;
                if (mismatches <= 10)
                    $display("Mismatch: expected %0d/%0b/%0b, got %0d/%0b/%0b",
                             want.sorted_value, want.final_res, want.overflowed,
                             got.sorted_value, got.final_res, got.overflowed);
            end
        endfunction
    endclass

    logic    clk          = 1'b0;
    logic    rst_n        = 1'b0;
    logic    item_valid   = 1'b0;
    logic    item_stall;
    item_t   item         = '0;
    logic    result_valid;
    logic    result_stall = 1'b0;
    result_t result;

    int             cycle_count = 0;
    int             items_sent  = 0;
    sort_scoreboard sb          = new();

    bottom_up_merge_sorter_top #(
        .CAPACITY(CAPACITY_DEF)
    ) DUT (
        .clk(clk),
        .rst_n(rst_n),
        .item_valid(item_valid),
        .item_stall(item_stall),
        .item(item),
        .result_valid(result_valid),
        .result_stall(result_stall),
        .result(result)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Some tests failed");
            $finish;
        end
    end

    task automatic send_item(input item_t it);
        while (!(items_sent >= 150 && items_sent < 250) && $urandom_range(0, 99) < 19)
        begin
            item_valid <= 1'b0;
            @(posedge clk);
        end
        item_valid <= 1'b1;
        item       <= it;
        @(posedge clk);
        while (item_stall)
            @(posedge clk);
        sb.accept_item(it);
        items_sent = items_sent + 1;
    endtask

    task automatic send_list(input logic signed [DATA_W-1:0] vals [$]);
        item_t it;
        for (int i = 0; i < vals.size(); i++)
        begin
            it.value   = vals[i];
            it.is_last = (i == vals.size() - 1);
            send_item(it);
        end
    endtask

    function automatic logic signed [DATA_W-1:0] pick_value(value_style_t style);
        logic signed [DATA_W-1:0] v;
        case (style)
            VS_DUPS:   v = int'($urandom_range(0, 6)) - 3;
            VS_NARROW: v = int'($urandom_range(0, 2000)) - 1000;
            VS_EDGES:
            begin
                case ($urandom_range(0, 3))
                    0:       v = 32'sh8000_0000;
                    1:       v = 32'sh7fff_ffff;
                    2:       v = '0;
                    default: v = -1;
                endcase
            end
            default:   v = $urandom;
        endcase
        return v;
    endfunction

    task automatic send_random_set(input int len);
        item_t        it;
        value_style_t style;
        int           pick;
        pick = $urandom_range(0, 9);
        if (pick < 5)
            style = VS_WIDE;
        else if (pick < 7)
            style = VS_DUPS;
        else if (pick < 8)
            style = VS_EDGES;
        else
            style = VS_NARROW;
        for (int i = 0; i < len; i++)
        begin
            it.value   = pick_value(style);
            it.is_last = (i == len - 1);
            send_item(it);
        end
    endtask

    // Result side: random stalls, one long hold-off, and a stretch without stalls.
    initial
    begin
        int got;
        bit held;
        got  = 0;
        held = 1'b0;
        forever
        begin
            if (!held && got >= 100)
            begin
                held = 1'b1;
                for (int i = 0; i < 400; i++)
                begin
                    result_stall <= 1'b1;
                    @(posedge clk);
                end
            end
            if (got >= 150 && got < 300)
                result_stall <= 1'b0;
            else
                result_stall <= ($urandom_range(0, 99) < 19);
            @(posedge clk);
            if (rst_n && result_valid && !result_stall)
            begin
                sb.check_result(result);
                got = got + 1;
            end
        end
    end

    initial
    begin
        int len;
        int pick;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        send_list('{32'sh7fff_ffff});
        send_list('{32'sh8000_0000});
        send_list('{-2, 3});
        send_list('{0, -1, 1, 32'sh7fff_ffff, 32'sh8000_0000});
        send_list('{5, 5, -5, 5, -5});
        send_list('{7, 6, 5, 4, 3, 2, 1, 0});

        send_random_set(CAPACITY_DEF);
        send_random_set(CAPACITY_DEF + 2);
        while (items_sent < 400)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 2)
                len = CAPACITY_DEF;
            else if (pick < 4)
                len = CAPACITY_DEF + $urandom_range(1, 5);
            else if (pick < 14)
                len = 1;
            else
                len = $urandom_range(2, 16);
            send_random_set(len);
        end
        item_valid <= 1'b0;

        while (sb.pending() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);

        if (sb.mismatches == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
